>>> hw/rtl/uerd_pkg.sv
// Package for the USB Ethernet receive deframer.
// Holds beat and configuration types, register indexes, status codes and widths.
// No dependencies.
`timescale 1ns / 1ps

package uerd_pkg;

    localparam int LEN_BITS   = 14;
    localparam int LEN_SHIFT  = 16;
    localparam int WORD_BITS  = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_MASK = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_MASK  = 2'd2;

    localparam logic [LEN_BITS-1:0]  MAX_LENGTH_RST  = 14'd1514;
    localparam logic [WORD_BITS-1:0] LENGTH_MASK_RST = 32'h3FFF_0000;
    localparam logic [WORD_BITS-1:0] ERROR_MASK_RST  = 32'h0000_8000;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_BIG   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       transfer_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                first_flag;
        logic                last_flag;
        logic [1:0]          status_code;
        logic [LEN_BITS-1:0] frame_length;
    } out_beat_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]  max_length;
        logic [WORD_BITS-1:0] length_mask;
        logic [WORD_BITS-1:0] error_mask;
    } cfg_t;

endpackage

>>> hw/rtl/uerd_core.sv
// Deframer state machine: header gathering, length and error checks, payload marking.
// Depends on uerd_pkg.
`timescale 1ns / 1ps

module uerd_core
    import uerd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      beat_vld,
    input  in_beat_t  beat,
    input  cfg_t      cfg,
    output logic      res_vld,
    output out_beat_t res
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    logic [1:0]           phase_reg,     phase_next;
    logic [1:0]           hdr_cnt_reg,   hdr_cnt_next;
    logic [23:0]          hdr_word_reg,  hdr_word_next;
    logic [LEN_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic                 at_first_reg,  at_first_next;
    logic [LEN_BITS-1:0]  pkt_len_reg,   pkt_len_next;

    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] masked;
    logic [LEN_BITS-1:0]  len;
    logic [LEN_BITS-1:0]  dec;
    logic                 emit;

    assign word   = {beat.data_byte, hdr_word_reg};
    assign masked = word & cfg.length_mask;
    assign len    = masked[LEN_SHIFT +: LEN_BITS];
    assign dec    = bytes_left_reg - {{(LEN_BITS-1){1'b0}}, (bytes_left_reg != '0)};
    assign res_vld = beat_vld && emit;

    always_comb begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_word_next   = hdr_word_reg;
        bytes_left_next = bytes_left_reg;
        at_first_next   = at_first_reg;
        pkt_len_next    = pkt_len_reg;
        emit            = 1'b0;
        res             = '0;
        res.frame_length = pkt_len_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_cnt_reg != 2'd3) begin
                    unique case (hdr_cnt_reg)
                        2'd0:    hdr_word_next = {16'd0, beat.data_byte};
                        2'd1:    hdr_word_next[15:8] = beat.data_byte;
                        default: hdr_word_next[23:16] = beat.data_byte;
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    if (beat.transfer_end) begin
                        hdr_cnt_next    = 2'd0;
                        bytes_left_next = '0;
                        at_first_next   = 1'b1;
                    end
                end else begin
                    hdr_cnt_next     = 2'd0;
                    pkt_len_next     = len;
                    res.frame_length = len;
                    res.last_flag    = 1'b1;
                    if ((word & cfg.error_mask) != '0) begin
                        emit            = 1'b1;
                        res.status_code = ST_ERROR;
                        if (beat.transfer_end || len == '0) begin
                            bytes_left_next = '0;
                            at_first_next   = 1'b1;
                        end else begin
                            phase_next      = PH_SKIP;
                            bytes_left_next = len;
                        end
                    end else if (len > cfg.max_length) begin
                        emit            = 1'b1;
                        res.status_code = ST_BIG;
                        if (beat.transfer_end) begin
                            bytes_left_next = '0;
                            at_first_next   = 1'b1;
                        end else begin
                            phase_next = PH_DROP;
                        end
                    end else if (len == '0) begin
                        bytes_left_next = '0;
                        at_first_next   = 1'b1;
                    end else if (beat.transfer_end) begin
                        emit            = 1'b1;
                        res.status_code = ST_TRUNC;
                        bytes_left_next = '0;
                        at_first_next   = 1'b1;
                    end else begin
                        phase_next      = PH_PAYLOAD;
                        bytes_left_next = len;
                        at_first_next   = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit            = 1'b1;
                res.out_byte    = beat.data_byte;
                res.first_flag  = at_first_reg;
                at_first_next   = 1'b0;
                bytes_left_next = dec;
                if (dec == '0 || beat.transfer_end) begin
                    res.last_flag   = 1'b1;
                    res.status_code = (dec == '0) ? ST_DATA : ST_TRUNC;
                    phase_next      = PH_HEADER;
                    hdr_cnt_next    = 2'd0;
                    bytes_left_next = '0;
                    at_first_next   = 1'b1;
                end
            end
            PH_SKIP: begin
                bytes_left_next = dec;
                if (dec == '0 || beat.transfer_end) begin
                    phase_next      = PH_HEADER;
                    hdr_cnt_next    = 2'd0;
                    bytes_left_next = '0;
                    at_first_next   = 1'b1;
                end
            end
            default: begin
                if (beat.transfer_end) begin
                    phase_next      = PH_HEADER;
                    hdr_cnt_next    = 2'd0;
                    bytes_left_next = '0;
                    at_first_next   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= 2'd0;
            bytes_left_reg <= '0;
            at_first_reg   <= 1'b1;
            pkt_len_reg    <= '0;
        end else if (beat_vld) begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            bytes_left_reg <= bytes_left_next;
            at_first_reg   <= at_first_next;
            pkt_len_reg    <= pkt_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_vld) begin
            hdr_word_reg <= hdr_word_next;
        end
    end

endmodule

>>> hw/rtl/usb_ethernet_rx_deframer.sv
// Top level of the USB Ethernet receive deframer: input register, configuration
// registers, deframer core and a two-entry output buffer. Depends on uerd_pkg, uerd_core.
//
//   port group   dir  handshake        payload
//   s_*          in   s_valid/s_ready  in_beat_t  (data_byte, transfer_end)
//   m_*          out  m_valid/m_ready  out_beat_t (out_byte, flags, status, length)
//   cfg_*        in   cfg_we           cfg_addr, cfg_wdata
//
// One beat per cycle while the output buffer is not full; the rate is set by the
// header/payload state update in uerd_core. Results are registered in the output buffer.
// aresetn is synchronous, active low; it restores the register defaults.
// The output buffer holds two results, so s_ready depends on registers only;
// a stalled m_ready back-pressures s_ready once both entries are full.
`timescale 1ns / 1ps

module usb_ethernet_rx_deframer
    import uerd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_BITS-1:0]  cfg_wdata
);

    cfg_t      cfg_reg;
    in_beat_t  in_reg;
    logic      in_vld_reg;
    logic      fire;
    logic      res_vld;
    out_beat_t res;

    out_beat_t buf_reg [2];
    logic      wr_ptr_reg;
    logic      rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic      push;
    logic      pop;

    assign fire    = in_vld_reg && (cnt_reg != 2'd2);
    assign s_ready = !in_vld_reg || fire;
    assign push    = res_vld;
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_length  <= MAX_LENGTH_RST;
            cfg_reg.length_mask <= LENGTH_MASK_RST;
            cfg_reg.error_mask  <= ERROR_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_wdata[LEN_BITS-1:0];
                REG_LENGTH_MASK: cfg_reg.length_mask <= cfg_wdata;
                REG_ERROR_MASK:  cfg_reg.error_mask  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    uerd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_vld (fire),
        .beat     (in_reg),
        .cfg      (cfg_reg),
        .res_vld  (res_vld),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> tb/rx_deframe_checker.sv
// Result checker for the USB Ethernet receive deframer: tracks register writes,
// predicts the result of every accepted input beat and compares result beats in order.
// Depends on uerd_pkg.
`timescale 1ns / 1ps

module rx_deframe_checker
    import uerd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_beat_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_BITS-1:0]  cfg_wdata,
    output int                    pending_results,
    output int                    mismatch_count
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DROP
    } deframe_phase_e;

    logic [LEN_BITS-1:0]  max_len;
    logic [WORD_BITS-1:0] len_mask;
    logic [WORD_BITS-1:0] err_mask;

    deframe_phase_e       phase_q;
    logic [1:0]           hdr_count;
    logic [WORD_BITS-1:0] hdr_word;
    logic [LEN_BITS-1:0]  bytes_left;
    logic                 at_first;
    logic [LEN_BITS-1:0]  pkt_len;

    out_beat_t expected_beats[$];

    initial begin
        pending_results = 0;
        mismatch_count  = 0;
    end

    task report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("%0t ns deframer mismatch: %s", $time, msg);
        end
    endtask

    task restart_header();
        phase_q    = PH_HEADER;
        hdr_count  = 2'd0;
        bytes_left = '0;
        at_first   = 1'b1;
    endtask

    function automatic out_beat_t status_beat(input logic [1:0] code, input logic [LEN_BITS-1:0] len);
        out_beat_t r;
        r              = '0;
        r.last_flag    = 1'b1;
        r.status_code  = code;
        r.frame_length = len;
        return r;
    endfunction

    task predict_deframe(input in_beat_t beat);
        logic [7:0] b;
        logic       fin;
        logic       lead;
        out_beat_t  r;
        b   = beat.data_byte;
        fin = beat.transfer_end;
        case (phase_q)
            PH_HEADER: begin
                if (hdr_count == 2'd0) begin
                    hdr_word = {24'd0, b};
                end else begin
                    hdr_word = hdr_word | ({24'd0, b} << (8 * hdr_count));
                end
                if (hdr_count < 2'd3) begin
                    hdr_count = hdr_count + 2'd1;
                    if (fin) begin
                        restart_header();
                    end
                end else begin
                    hdr_count = 2'd0;
                    pkt_len   = LEN_BITS'((hdr_word & len_mask) >> LEN_SHIFT);
                    if ((hdr_word & err_mask) != '0) begin
                        expected_beats.push_back(status_beat(ST_ERROR, pkt_len));
                        if (fin || pkt_len == '0) begin
                            restart_header();
                        end else begin
                            phase_q    = PH_SKIP;
                            bytes_left = pkt_len;
                        end
                    end else if (pkt_len > max_len) begin
                        expected_beats.push_back(status_beat(ST_BIG, pkt_len));
                        if (fin) begin
                            restart_header();
                        end else begin
                            phase_q = PH_DROP;
                        end
                    end else if (pkt_len == '0) begin
                        restart_header();
                    end else if (fin) begin
                        expected_beats.push_back(status_beat(ST_TRUNC, pkt_len));
                        restart_header();
                    end else begin
                        phase_q    = PH_PAYLOAD;
                        bytes_left = pkt_len;
                        at_first   = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                lead     = at_first;
                at_first = 1'b0;
                if (bytes_left != '0) begin
                    bytes_left = bytes_left - 1'b1;
                end
                r              = '0;
                r.out_byte     = b;
                r.first_flag   = lead;
                r.frame_length = pkt_len;
                r.status_code  = ST_DATA;
                if (bytes_left == '0) begin
                    r.last_flag = 1'b1;
                    restart_header();
                end else if (fin) begin
                    r.last_flag   = 1'b1;
                    r.status_code = ST_TRUNC;
                    restart_header();
                end
                expected_beats.push_back(r);
            end
            PH_SKIP: begin
                if (bytes_left != '0) begin
                    bytes_left = bytes_left - 1'b1;
                end
                if (bytes_left == '0 || fin) begin
                    restart_header();
                end
            end
            default: begin
                if (fin) begin
                    restart_header();
                end
            end
        endcase
    endtask

    task check_result(input out_beat_t got);
        out_beat_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte=%h status=%0d len=%0d",
                got.out_byte, got.status_code, got.frame_length));
        end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.first_flag !== want.first_flag)
                report_mismatch($sformatf("first_flag %b, want %b",
                    got.first_flag, want.first_flag));
            if (got.last_flag !== want.last_flag)
                report_mismatch($sformatf("last_flag %b, want %b",
                    got.last_flag, want.last_flag));
            if (got.status_code !== want.status_code)
                report_mismatch($sformatf("status_code %0d, want %0d",
                    got.status_code, want.status_code));
            if (got.frame_length !== want.frame_length)
                report_mismatch($sformatf("frame_length %0d, want %0d",
                    got.frame_length, want.frame_length));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_len  = MAX_LENGTH_RST;
            len_mask = LENGTH_MASK_RST;
            err_mask = ERROR_MASK_RST;
            hdr_word = '0;
            pkt_len  = '0;
            restart_header();
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAX_LENGTH:  max_len  = cfg_wdata[LEN_BITS-1:0];
                    REG_LENGTH_MASK: len_mask = cfg_wdata;
                    REG_ERROR_MASK:  err_mask = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (s_valid && s_ready) begin
                predict_deframe(s_data);
            end
        end
        pending_results = expected_beats.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the receive deframer testbench: clock, reset, register set-up, framed byte
// stimulus with random gaps, result back-pressure and the verdict.
// Depends on uerd_pkg, usb_ethernet_rx_deframer and rx_deframe_checker.
`timescale 1ns / 1ps

module testbench;

    import uerd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BEATS = 275;
    localparam int NUM_PHASES  = 7;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [WORD_BITS-1:0]  cfg_wdata;

    int pending_results;
    int mismatch_count;
    int cycle_count = 0;
    int beats_sent  = 0;
    bit src_burst;
    bit sink_burst;

    logic [LEN_BITS-1:0]  cur_max_len;
    logic [WORD_BITS-1:0] cur_len_mask;
    logic [WORD_BITS-1:0] cur_err_mask;

    logic [LEN_BITS-1:0]  max_tbl [NUM_PHASES] = '{14'd0, 14'd16383, 14'd6, 14'd10, 14'd12,
                                                   14'd0, 14'd1514};
    logic [WORD_BITS-1:0] lmask_tbl [NUM_PHASES] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                     32'h003F_0000, 32'h0000_0000,
                                                     32'h3FFF_0000, 32'h0000_0000,
                                                     32'h3FFF_0000};
    logic [WORD_BITS-1:0] emask_tbl [NUM_PHASES] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                     32'h8000_0001, 32'hFFFF_FFFF,
                                                     32'h0000_8000, 32'h0000_0000,
                                                     32'h0000_8000};

    usb_ethernet_rx_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rx_deframe_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [LEN_BITS-1:0] frame_len_of(input logic [WORD_BITS-1:0] word);
        return LEN_BITS'((word & cur_len_mask) >> LEN_SHIFT);
    endfunction

    task send_beat(input in_beat_t beat);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Header bytes go out low byte first; when close is set, the end flag lands on the last byte sent.
    task send_frame(input logic [WORD_BITS-1:0] word, input int n, input bit close);
        int i;
        for (i = 0; i < 4; i++) begin
            send_beat({word[8*i +: 8], close && n == 0 && i == 3});
        end
        for (i = 0; i < n; i++) begin
            send_beat({8'($urandom), close && i == n - 1});
        end
    endtask

    task send_random_frame();
        int kind;
        int n;
        int i;
        int lv;
        bit close;
        logic [WORD_BITS-1:0] word;
        logic [LEN_BITS-1:0]  len;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                send_beat({8'($urandom), i == n - 1});
            end
        end else if (kind < 10) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                send_beat({8'($urandom), 1'($urandom)});
            end
        end else begin
            word = $urandom;
            case ($urandom_range(0, 15))
                10, 11:  lv = int'(cur_max_len) + $urandom_range(0, 1);
                12:      lv = 16383;
                13, 14, 15: lv = $urandom_range(0, 65535);
                default: lv = $urandom_range(0, 12);
            endcase
            word[31:16] = lv[15:0];
            if ($urandom_range(0, 7) != 0) begin
                word = word & ~cur_err_mask;
            end
            len   = frame_len_of(word);
            close = ($urandom_range(0, 2) == 0);
            if ((word & cur_err_mask) != '0) begin
                if (len > 24) begin
                    n     = $urandom_range(0, 6);
                    close = 1'b1;
                end else begin
                    n = len;
                end
            end else if (len > cur_max_len) begin
                n = $urandom_range(0, 4);
            end else if (len > 24 || (len != '0 && $urandom_range(0, 9) == 0)) begin
                n     = $urandom_range(0, len > 24 ? 6 : int'(len) - 1);
                close = 1'b1;
            end else begin
                n = len;
            end
            send_frame(word, n, close);
        end
    endtask

    task load_limits(input logic [LEN_BITS-1:0] max_len, input logic [WORD_BITS-1:0] lmask,
                     input logic [WORD_BITS-1:0] emask);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MAX_LENGTH;
        cfg_wdata <= WORD_BITS'(max_len);
        @(negedge aclk);
        cfg_addr  <= REG_LENGTH_MASK;
        cfg_wdata <= lmask;
        @(negedge aclk);
        cfg_addr  <= REG_ERROR_MASK;
        cfg_wdata <= emask;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur_max_len  = max_len;
        cur_len_mask = lmask;
        cur_err_mask = emask;
    endtask

    task wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
        repeat (6) @(negedge aclk);
    endtask

    // Result side: hold ready low for a random gap (none during a burst), then take one beat.
    initial begin
        int gap;
        m_ready    = 1'b0;
        sink_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0) begin
                sink_burst = !sink_burst;
            end
            gap = sink_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int p;
        int target;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_MAX_LENGTH;
        cfg_wdata    = '0;
        src_burst    = 1'b0;
        cur_max_len  = MAX_LENGTH_RST;
        cur_len_mask = LENGTH_MASK_RST;
        cur_err_mask = ERROR_MASK_RST;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_frame(32'h0001_00FF, 1, 1'b0);
        send_frame(32'h0001_8000, 1, 1'b0);
        send_frame(32'hFFFF_7F00, 1, 1'b1);
        send_frame(32'h0000_0000, 0, 1'b0);
        send_frame(32'h0002_0000, 0, 1'b1);
        send_beat({8'hA5, 1'b0});
        send_beat({8'h5A, 1'b1});
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == 5) begin
                load_limits(LEN_BITS'($urandom_range(0, 30)), $urandom,
                            $urandom & $urandom & $urandom);
            end else begin
                load_limits(max_tbl[p], lmask_tbl[p], emask_tbl[p]);
            end
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                send_random_frame();
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
